@@ rtl/core/rpc_pkg.sv @@
// Shared types, constants and helper functions for the rectangular/polar converter.
package rpc_pkg;

  localparam int ITERATIONS_DEF = 16;
  localparam int TABLE_LEN      = 24;
  localparam int XW             = 34;
  localparam int ZW             = 34;
  localparam int PW             = 36;
  localparam int SPLIT          = 17;

  localparam logic signed [PW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [PW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [PW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [30:0]   INV_GAIN_Q30 = 31'sd652032874;

  localparam logic [29:0] ATAN_Q30 [TABLE_LEN] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
    30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
    30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
    30'd262144,    30'd131072,    30'd65536,     30'd32768,
    30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128
  };

  typedef struct packed {
    logic mode;
    logic re_zero;
    logic re_neg;
    logic im_neg;
    logic flip;
  } rpc_flags_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } rpc_vec_t;

  typedef struct packed {
    logic               mode;
    logic signed [16:0] first;
    logic signed [16:0] second;
  } rpc_res_t;

  function automatic logic signed [16:0] sat17(input logic signed [39:0] v);
    logic signed [16:0] r;
    if (v > 40'sd65535) begin
      r = 17'sd65535;
    end else if (v < -40'sd65536) begin
      r = -17'sd65536;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

  // one step of whole-turn reduction towards -PI..PI
  function automatic logic signed [PW-1:0] reduce_turn(input logic signed [PW-1:0] z);
    logic signed [PW-1:0] r;
    if (z > PI_Q30) begin
      r = z - TWO_PI_Q30;
    end else if (z < -PI_Q30) begin
      r = z + TWO_PI_Q30;
    end else begin
      r = z;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/rpc_in_if.sv @@
// Input channel interface: one complex bin and a mode per transaction.
interface rpc_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [16:0] first_value;
  logic signed [16:0] second_value;

  modport source (output valid, output mode, output first_value, output second_value,
                  input ready);
  modport sink   (input valid, input mode, input first_value, input second_value,
                  output ready);
endinterface

@@ rtl/core/rpc_out_if.sv @@
// Result channel interface: one converted pair per transaction.
interface rpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] first_result;
  logic signed [16:0] second_result;

  modport source (output valid, output first_result, output second_result, input ready);
  modport sink   (input valid, input first_result, input second_result, output ready);
endinterface

@@ rtl/core/rect_polar_converter_top.sv @@
// Top level: pipelined CORDIC rectangular/polar converter with output skid buffer.
//
//  channel   | direction | payload
//  ----------+-----------+---------------------------------------------
//  in_chan   | sink      | mode, first_value, second_value (17b signed)
//  out_chan  | source    | first_result, second_result (17b signed)
//
// One transaction per cycle while the skid register is empty; the pipeline is
// five front-end stages, one CORDIC cell per iteration and two back-end stages.
// Synchronous active-low reset clears the valid bits and the skid buffer.
// A stalled result moves into the skid register; while it is full the whole
// pipeline holds and in_chan.ready is low.
module rect_polar_converter_top #(
  parameter int ITERATIONS = rpc_pkg::ITERATIONS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  rpc_in_if.sink   in_chan,
  rpc_out_if.source out_chan
);

  logic                en;
  logic                cell_valid [ITERATIONS+1];
  rpc_pkg::rpc_flags_t cell_flags [ITERATIONS+1];
  rpc_pkg::rpc_vec_t   cell_vec   [ITERATIONS+1];
  logic                post_valid;
  rpc_pkg::rpc_res_t   post_res;
  logic                skid_valid_r, skid_valid_nxt;
  rpc_pkg::rpc_res_t   skid_r;

  assign en            = !skid_valid_r;
  assign in_chan.ready = en;

  rpc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_chan.valid),
    .in_mode   (in_chan.mode),
    .in_first  (in_chan.first_value),
    .in_second (in_chan.second_value),
    .out_valid (cell_valid[0]),
    .out_flags (cell_flags[0]),
    .out_vec   (cell_vec[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    rpc_cell #(.STAGE(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (cell_valid[i]),
      .in_flags  (cell_flags[i]),
      .in_vec    (cell_vec[i]),
      .out_valid (cell_valid[i+1]),
      .out_flags (cell_flags[i+1]),
      .out_vec   (cell_vec[i+1])
    );
  end

  rpc_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cell_valid[ITERATIONS]),
    .in_flags  (cell_flags[ITERATIONS]),
    .in_vec    (cell_vec[ITERATIONS]),
    .out_valid (post_valid),
    .out_res   (post_res)
  );

  always_comb begin
    if (skid_valid_r) begin
      skid_valid_nxt = !out_chan.ready;
    end else begin
      skid_valid_nxt = post_valid && !out_chan.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else begin
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid_r) begin
      skid_r <= post_res;
    end
  end

  assign out_chan.valid         = skid_valid_r || post_valid;
  assign out_chan.first_result  = skid_valid_r ? skid_r.first  : post_res.first;
  assign out_chan.second_result = skid_valid_r ? skid_r.second : post_res.second;

`ifndef SYNTH
  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid && in_chan.ready)
    else $error("pipeline not empty after reset");

  a_skid_load : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(post_valid && !out_chan.ready))
    else $error("skid buffer filled without a stalled result");

  a_mag_sign : assert property (@(posedge clk) disable iff (!rst_n)
    post_valid && !post_res.mode |-> !post_res.first[16])
    else $error("negative magnitude from vectoring");
`endif

endmodule

@@ rtl/core/rpc_prep.sv @@
// Front end: scaling, gain pre-compensation, turn reduction and half-plane fold.
module rpc_prep (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic                    in_mode,
  input  logic signed [16:0]      in_first,
  input  logic signed [16:0]      in_second,
  output logic                    out_valid,
  output rpc_pkg::rpc_flags_t     out_flags,
  output rpc_pkg::rpc_vec_t       out_vec
);

  localparam int XW = rpc_pkg::XW;
  localparam int ZW = rpc_pkg::ZW;
  localparam int PW = rpc_pkg::PW;

  logic                  v1_r, v2_r, v3_r, v4_r, v5_r;
  rpc_pkg::rpc_flags_t   f1_r, f2_r, f3_r, f4_r, f5_r;
  rpc_pkg::rpc_flags_t   f1_nxt, f5_nxt;
  logic signed [XW-1:0]  x1_r, x2_r, x3_r, x4_r, x5_r;
  logic signed [XW-1:0]  y1_r, y2_r, y3_r, y4_r, y5_r;
  logic signed [XW-1:0]  x1_nxt, y1_nxt, x2_nxt;
  logic signed [PW-1:0]  z1_r, z2_r, z3_r, z4_r;
  logic signed [PW-1:0]  z1_nxt, z2_nxt, z3_nxt, z4_nxt, z5_full;
  logic signed [ZW-1:0]  z5_r;
  logic signed [47:0]    prod1_r, prod1_nxt;
  logic signed [47:0]    prod_rnd;
  logic signed [XW-1:0]  re_s, im_s;
  logic                  neg;

  always_comb begin
    re_s      = {{(XW-31){in_first[16]}}, in_first, 14'b0};
    im_s      = {{(XW-31){in_second[16]}}, in_second, 14'b0};
    neg       = !in_mode && in_first[16];
    x1_nxt    = neg ? -re_s : re_s;
    y1_nxt    = in_mode ? '0 : (neg ? -im_s : im_s);
    z1_nxt    = in_mode ? {{(PW-35){in_second[16]}}, in_second, 18'b0} : '0;
    prod1_nxt = in_first * rpc_pkg::INV_GAIN_Q30;
    f1_nxt    = '{mode: in_mode, re_zero: (in_first == '0), re_neg: neg,
                  im_neg: in_second[16], flip: 1'b0};
  end

  always_comb begin
    prod_rnd = prod1_r + 48'sd32768;
    x2_nxt   = f1_r.mode ? XW'(prod_rnd >>> 16) : x1_r;
    z2_nxt   = rpc_pkg::reduce_turn(z1_r);
    z3_nxt   = rpc_pkg::reduce_turn(z2_r);
    z4_nxt   = rpc_pkg::reduce_turn(z3_r);
  end

  always_comb begin
    f5_nxt = f4_r;
    priority if (z4_r > rpc_pkg::HALF_PI_Q30) begin
      z5_full     = z4_r - rpc_pkg::PI_Q30;
      f5_nxt.flip = 1'b1;
    end else if (z4_r < -rpc_pkg::HALF_PI_Q30) begin
      z5_full     = z4_r + rpc_pkg::PI_Q30;
      f5_nxt.flip = 1'b1;
    end else begin
      z5_full     = z4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r    <= f1_nxt;
      x1_r    <= x1_nxt;
      y1_r    <= y1_nxt;
      z1_r    <= z1_nxt;
      prod1_r <= prod1_nxt;
      f2_r    <= f1_r;
      x2_r    <= x2_nxt;
      y2_r    <= y1_r;
      z2_r    <= z2_nxt;
      f3_r    <= f2_r;
      x3_r    <= x2_r;
      y3_r    <= y2_r;
      z3_r    <= z3_nxt;
      f4_r    <= f3_r;
      x4_r    <= x3_r;
      y4_r    <= y3_r;
      z4_r    <= z4_nxt;
      f5_r    <= f5_nxt;
      x5_r    <= x4_r;
      y5_r    <= y4_r;
      z5_r    <= z5_full[ZW-1:0];
    end
  end

  assign out_valid = v5_r;
  assign out_flags = f5_r;
  assign out_vec   = '{x: x5_r, y: y5_r, z: z5_r};

endmodule

@@ rtl/core/rpc_cell.sv @@
// One CORDIC micro-rotation stage, vectoring or rotation per transaction.
module rpc_cell #(
  parameter int STAGE = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  rpc_pkg::rpc_flags_t in_flags,
  input  rpc_pkg::rpc_vec_t   in_vec,
  output logic                out_valid,
  output rpc_pkg::rpc_flags_t out_flags,
  output rpc_pkg::rpc_vec_t   out_vec
);

  localparam int XW = rpc_pkg::XW;
  localparam int ZW = rpc_pkg::ZW;

  logic                 valid_r;
  rpc_pkg::rpc_flags_t  flags_r;
  rpc_pkg::rpc_vec_t    vec_r, vec_nxt;
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] ang;
  logic                 pos;

  always_comb begin
    dx  = in_vec.y >>> STAGE;
    dy  = in_vec.x >>> STAGE;
    ang = {{(ZW-30){1'b0}}, rpc_pkg::ATAN_Q30[STAGE]};
    // rotation follows the residual angle, vectoring drives y to zero
    pos = in_flags.mode ? !in_vec.z[ZW-1] : (in_vec.y[XW-1] || (in_vec.y == '0));
    if (pos) begin
      vec_nxt.x = in_vec.x - dx;
      vec_nxt.y = in_vec.y + dy;
      vec_nxt.z = in_vec.z - ang;
    end else begin
      vec_nxt.x = in_vec.x + dx;
      vec_nxt.y = in_vec.y - dy;
      vec_nxt.z = in_vec.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags_r <= in_flags;
      vec_r   <= vec_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_flags = flags_r;
  assign out_vec   = vec_r;

endmodule

@@ rtl/core/rpc_post.sv @@
// Back end: gain compensation, phase correction, rounding and saturation.
module rpc_post (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  rpc_pkg::rpc_flags_t in_flags,
  input  rpc_pkg::rpc_vec_t   in_vec,
  output logic                out_valid,
  output rpc_pkg::rpc_res_t   out_res
);

  localparam int XW    = rpc_pkg::XW;
  localparam int ZW    = rpc_pkg::ZW;
  localparam int PW    = rpc_pkg::PW;
  localparam int SPLIT = rpc_pkg::SPLIT;
  localparam int HW    = XW - SPLIT;

  logic                   v1_r, v2_r;
  logic                   mode1_r;
  logic signed [47:0]     pp_hi_r, pp_hi_nxt;
  logic        [46:0]     pp_lo_r, pp_lo_nxt;
  logic signed [ZW:0]     zf_r, zf_nxt;
  logic signed [XW-1:0]   xf_r, xf_nxt, yf_r, yf_nxt;
  logic signed [PW-1:0]   zw, zc;
  logic signed [HW-1:0]   xh;
  logic        [SPLIT-1:0] xl;
  rpc_pkg::rpc_res_t      res_r, res_nxt;
  logic signed [65:0]     mag_sum;
  logic signed [PW-1:0]   ph_sum;
  logic signed [XW:0]     re_sum, im_sum;

  always_comb begin
    xh        = in_vec.x[XW-1:SPLIT];
    xl        = in_vec.x[SPLIT-1:0];
    pp_hi_nxt = xh * rpc_pkg::INV_GAIN_Q30;
    pp_lo_nxt = xl * rpc_pkg::INV_GAIN_Q30[29:0];
    zw        = PW'(in_vec.z);
    priority if (in_flags.re_zero) begin
      zc = in_flags.im_neg ? -rpc_pkg::HALF_PI_Q30 : rpc_pkg::HALF_PI_Q30;
    end else if (in_flags.re_neg) begin
      zc = zw + (in_flags.im_neg ? -rpc_pkg::PI_Q30 : rpc_pkg::PI_Q30);
    end else begin
      zc = zw;
    end
    zf_nxt = zc[ZW:0];
    xf_nxt = in_flags.flip ? -in_vec.x : in_vec.x;
    yf_nxt = in_flags.flip ? -in_vec.y : in_vec.y;
  end

  always_comb begin
    mag_sum = (66'(pp_hi_r) <<< SPLIT) + 66'($signed({1'b0, pp_lo_r})) + (66'sd1 <<< 43);
    ph_sum  = PW'(zf_r) + (36'sd1 <<< 17);
    re_sum  = (XW+1)'(xf_r) + (35'sd1 <<< 13);
    im_sum  = (XW+1)'(yf_r) + (35'sd1 <<< 13);
    res_nxt.mode = mode1_r;
    if (mode1_r) begin
      res_nxt.first  = rpc_pkg::sat17(40'($signed(re_sum[XW:14])));
      res_nxt.second = rpc_pkg::sat17(40'($signed(im_sum[XW:14])));
    end else begin
      res_nxt.first  = rpc_pkg::sat17(40'($signed(mag_sum[65:44])));
      res_nxt.second = rpc_pkg::sat17(40'($signed(ph_sum[PW-1:18])));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r <= in_flags.mode;
      pp_hi_r <= pp_hi_nxt;
      pp_lo_r <= pp_lo_nxt;
      zf_r    <= zf_nxt;
      xf_r    <= xf_nxt;
      yf_r    <= yf_nxt;
      res_r   <= res_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_res   = res_r;

endmodule

@@ sim/tb.sv @@
// Testbench for the CORDIC rectangular/polar converter: directed corners, random bins, back-pressure.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  NUM_ITER     = rpc_pkg::ITERATIONS_DEF;
  localparam int  ITER_USED    = (NUM_ITER > 24) ? 24 : NUM_ITER;
  localparam int  DRAIN_CYCLES = NUM_ITER + 7 + 10;
  localparam int  CYCLE_LIMIT  = 200000;

  localparam logic MODE_TO_POLAR = 1'b0;
  localparam logic MODE_TO_RECT  = 1'b1;

  localparam longint PI_Q      = 64'sd3373259426;
  localparam longint HALF_PI_Q = 64'sd1686629713;
  localparam longint TWO_PI_Q  = 64'sd6746518852;
  localparam longint INV_GAIN  = 64'sd652032874;
  localparam longint ATAN_TAB [24] = '{
    64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
    64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
    64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
    64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
    64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
    64'sd1024,      64'sd512,       64'sd256,       64'sd128
  };

  typedef struct packed {
    logic signed [16:0] first;
    logic signed [16:0] second;
  } bin_result_t;

  logic clk;
  logic rst_n;
  int   cycle_cnt;
  int   mismatch_cnt;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_left;
  bin_result_t expected_pairs [$];

  rpc_in_if  in_chan ();
  rpc_out_if out_chan ();

  rect_polar_converter_top #(.ITERATIONS(NUM_ITER)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [16:0] clamp17(input longint v);
    if (v > 64'sd65535) begin
      return 17'sd65535;
    end
    if (v < -64'sd65536) begin
      return -17'sd65536;
    end
    return v[16:0];
  endfunction

  // add half an LSB, then floor shift
  function automatic longint round_down(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic bin_result_t vector_to_polar(input longint re, input longint im);
    bin_result_t r;
    longint x, y, z, dx, dy;
    x = re * 16384;
    y = im * 16384;
    z = 0;
    if (re < 0) begin
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ITER_USED; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + ATAN_TAB[i];
      end else begin
        x = x - dx; y = y + dy; z = z - ATAN_TAB[i];
      end
    end
    r.first = clamp17(round_down(x * INV_GAIN, 44));
    if (re == 0) begin
      z = (im < 0) ? -HALF_PI_Q : HALF_PI_Q;
    end else if (re < 0) begin
      z = z + ((im < 0) ? -PI_Q : PI_Q);
    end
    r.second = clamp17(round_down(z, 18));
    return r;
  endfunction

  function automatic bin_result_t polar_to_vector(input longint mag, input longint phase);
    bin_result_t r;
    longint x, y, z, dx, dy;
    logic flip;
    z = phase * 262144;
    y = 0;
    flip = 1'b0;
    while (z > PI_Q) z = z - TWO_PI_Q;
    while (z < -PI_Q) z = z + TWO_PI_Q;
    if (z > HALF_PI_Q) begin
      z = z - PI_Q;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q) begin
      z = z + PI_Q;
      flip = 1'b1;
    end
    x = round_down(mag * 16384 * INV_GAIN, 30);
    for (int i = 0; i < ITER_USED; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ATAN_TAB[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ATAN_TAB[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    r.first  = clamp17(round_down(x, 14));
    r.second = clamp17(round_down(y, 14));
    return r;
  endfunction

  function automatic bin_result_t convert_bin(input logic mode, input logic signed [16:0] a,
                                              input logic signed [16:0] b);
    if (mode == MODE_TO_POLAR) begin
      return vector_to_polar(longint'(a), longint'(b));
    end
    return polar_to_vector(longint'(a), longint'(b));
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_bin(input logic mode, input logic signed [16:0] a,
                          input logic signed [16:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.mode         <= mode;
    in_chan.first_value  <= a;
    in_chan.second_value <= b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    expected_pairs.push_back(convert_bin(mode, a, b));
  endtask

  task automatic wait_drain();
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic note_mismatch(input string what, input bin_result_t want,
                               input bin_result_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%s at cycle %0d: expected %0d/%0d, got %0d/%0d", what, cycle_cnt,
               want.first, want.second, got.first, got.second);
    end
  endtask

  always @(posedge clk) begin : check_results
    bin_result_t want;
    bin_result_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.first  = out_chan.first_result;
      got.second = out_chan.second_result;
      if (expected_pairs.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_pairs.pop_front();
        if (got.first !== want.first) begin
          note_mismatch("first_result mismatch", want, got);
        end else if (got.second !== want.second) begin
          note_mismatch("second_result mismatch", want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [16:0] pick_component();
    int sel;
    sel = $urandom_range(99);
    if (sel < 12) begin
      case ($urandom_range(5))
        0:       return -17'sd65536;
        1:       return -17'sd65535;
        2:       return -17'sd1;
        3:       return 17'sd0;
        4:       return 17'sd1;
        default: return 17'sd65535;
      endcase
    end
    if (sel < 35) begin
      return 17'(int'($urandom_range(600)) - 300);
    end
    return 17'($urandom);
  endfunction

  function automatic logic signed [16:0] pick_phase();
    if ($urandom_range(99) < 70) begin
      return 17'(int'($urandom_range(25736)) - 12868);
    end
    return pick_component();
  endfunction

  function automatic logic signed [16:0] pick_magnitude();
    if ($urandom_range(99) < 75) begin
      return 17'($urandom_range(65535));
    end
    return pick_component();
  endfunction

  task automatic test_rect_to_polar_corners();
    send_bin(MODE_TO_POLAR, 17'sd0, 17'sd0);
    send_bin(MODE_TO_POLAR, 17'sd0, 17'sd5);
    send_bin(MODE_TO_POLAR, 17'sd0, -17'sd5);
    send_bin(MODE_TO_POLAR, -17'sd65536, 17'sd0);
    send_bin(MODE_TO_POLAR, 17'sd65535, 17'sd0);
    send_bin(MODE_TO_POLAR, -17'sd100, 17'sd50);
    send_bin(MODE_TO_POLAR, -17'sd100, -17'sd50);
    send_bin(MODE_TO_POLAR, -17'sd100, 17'sd0);
    send_bin(MODE_TO_POLAR, 17'sd65535, 17'sd65535);
    send_bin(MODE_TO_POLAR, -17'sd65536, -17'sd65536);
    send_bin(MODE_TO_POLAR, -17'sd65536, 17'sd65535);
    send_bin(MODE_TO_POLAR, 17'sd1, -17'sd1);
    send_bin(MODE_TO_POLAR, 17'sd3, 17'sd4);
  endtask

  task automatic test_polar_to_rect_corners();
    send_bin(MODE_TO_RECT, 17'sd1000, 17'sd0);
    send_bin(MODE_TO_RECT, 17'sd1000, 17'sd6434);
    send_bin(MODE_TO_RECT, 17'sd1000, -17'sd6434);
    send_bin(MODE_TO_RECT, 17'sd1000, 17'sd12868);
    send_bin(MODE_TO_RECT, 17'sd1000, 17'sd65535);
    send_bin(MODE_TO_RECT, 17'sd1000, -17'sd65536);
    send_bin(MODE_TO_RECT, -17'sd65536, 17'sd3000);
    send_bin(MODE_TO_RECT, 17'sd65535, 17'sd0);
    send_bin(MODE_TO_RECT, 17'sd65535, 17'sd3217);
    send_bin(MODE_TO_RECT, -17'sd1, -17'sd12868);
    send_bin(MODE_TO_RECT, 17'sd0, 17'sd100);
  endtask

  task automatic test_random_bins(input int snd_pct, input int rcv_pct, input int count);
    logic mode;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int k = 0; k < count; k++) begin
      mode = 1'($urandom_range(1));
      if (mode == MODE_TO_POLAR) begin
        send_bin(mode, pick_component(), pick_component());
      end else begin
        send_bin(mode, pick_magnitude(), pick_phase());
      end
    end
  endtask

  // receiver holds off long enough for the pipeline and skid register to fill
  task automatic test_backpressure_fill();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 150;
    for (int k = 0; k < 60; k++) begin
      send_bin(MODE_TO_RECT, pick_magnitude(), pick_phase());
    end
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.mode         <= MODE_TO_POLAR;
    in_chan.first_value  <= '0;
    in_chan.second_value <= '0;
    cycle_cnt     = 0;
    mismatch_cnt  = 0;
    hold_left     = 0;
    send_idle_pct = 38;
    recv_idle_pct = 60;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_rect_to_polar_corners();
    test_polar_to_rect_corners();
    test_random_bins(38, 60, 380);
    test_random_bins(60, 38, 380);
    test_random_bins(0, 0, 380);
    test_backpressure_fill();
    in_chan.valid <= 1'b0;
    recv_idle_pct = 0;
    wait_drain();

    if (mismatch_cnt == 0 && expected_pairs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
